FILE: rtl/shg_pkg.sv
// Shared types, constants and state encodings for the spatial hash grid sorter.
// No dependencies; the hash unit and the top level in rtl/ import this package.
package shg_pkg;

  // Sizing of the particle store and the hash table
  localparam int unsigned MAX_PARTICLES = 1024;
  localparam int unsigned TABLE_SIZE    = 2048;

  localparam int unsigned IDX_W    = $clog2(MAX_PARTICLES);
  localparam int unsigned CNT_W    = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned KEY_W    = $clog2(TABLE_SIZE);
  localparam int unsigned CS_DEPTH = TABLE_SIZE + 1;
  localparam int unsigned CS_AW    = $clog2(CS_DEPTH);

  // Fixed beat field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 20;
  localparam int unsigned INV_W  = 16;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned QKEY_W = 11;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned HKEY_W = 11;
  localparam int unsigned PIDX_W = 10;
  localparam int unsigned RNG_W  = 11;

  // Width used to compare a requested slot against the particle count
  localparam int unsigned CMP_W = CNT_W + SLOT_W;

  // Shared multiplier: signed position times zero-extended scale
  localparam int unsigned MUL_B_W = INV_W + 1;
  localparam int unsigned MUL_P_W = POS_W + MUL_B_W;
  // Q12.8 times Q8.8 leaves 16 fraction bits to drop
  localparam int unsigned FRAC_SH = 16;

  localparam logic [INV_W-1:0] INV_RESET = INV_W'(256);

  // Hash primes
  localparam logic [31:0] HASH_P1 = 32'd73856093;
  localparam logic [31:0] HASH_P2 = 32'd19349663;
  localparam logic [31:0] HASH_P3 = 32'd83492791;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR      = 3'd0,
    OP_INSERT     = 3'd1,
    OP_BUILD      = 3'd2,
    OP_READ_SLOT  = 3'd3,
    OP_READ_RANGE = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_BUILT = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // Top-level sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_ZERO,
    S_CNT_RD,
    S_CNT_KEY,
    S_CNT_INC,
    S_PRE_RD,
    S_PRE_WR,
    S_SCT_RD,
    S_SCT_KEY,
    S_SCT_WR,
    S_SLOT_OUT,
    S_RNG_A,
    S_RNG_B
  } state_e;

  // Cell and hash unit steps
  typedef enum logic [2:0] {
    H_IDLE,
    H_MX,
    H_MY,
    H_MZ,
    H_HX,
    H_HY,
    H_HZ,
    H_FIN
  } hstate_e;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [SLOT_W-1:0]        slot_index;
    logic [QKEY_W-1:0]        query_key;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic [HKEY_W-1:0]        hash_key;
    logic signed [POS_W-1:0]  cell_x;
    logic signed [POS_W-1:0]  cell_y;
    logic signed [POS_W-1:0]  cell_z;
    logic [PIDX_W-1:0]        particle_index;
    logic [RNG_W-1:0]         range_start;
    logic [RNG_W-1:0]         range_end;
  } rsp_t;

  // Request and answer between the sequencer and the hash unit
  typedef struct packed {
    logic                     start;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
  } hu_req_t;

  typedef struct packed {
    logic                     done;
    logic [KEY_W-1:0]         key;
    logic signed [POS_W-1:0]  cell_x;
    logic signed [POS_W-1:0]  cell_y;
    logic signed [POS_W-1:0]  cell_z;
  } hu_rsp_t;

endpackage

FILE: rtl/shg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module shg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/shg_hash_unit.sv
// Cell and hash computation on one shared registered multiplier.
// Depends on shg_pkg for widths, primes and the step encoding.
module shg_hash_unit
  import shg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [INV_W-1:0] inv_i,
  input  hu_req_t          req_i,
  output hu_rsp_t          rsp_o
);

  hstate_e state_q, state_d;

  logic signed [POS_W-1:0]   px_q, py_q, pz_q;
  logic signed [POS_W-1:0]   cx_q, cy_q, cz_q;
  logic [KEY_W-1:0]          acc_q;
  logic signed [MUL_P_W-1:0] prod_q, prod_d;
  logic signed [POS_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  // Step sequence: three scale multiplies, then three prime multiplies
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      H_IDLE:  if (req_i.start) state_d = H_MX;
      H_MX:    state_d = H_MY;
      H_MY:    state_d = H_MZ;
      H_MZ:    state_d = H_HX;
      H_HX:    state_d = H_HY;
      H_HY:    state_d = H_HZ;
      H_HZ:    state_d = H_FIN;
      H_FIN:   state_d = H_IDLE;
      default: state_d = H_IDLE;
    endcase
  end

  // Select multiplier operands per step
  always_comb begin
    mul_a = px_q;
    mul_b = $signed({1'b0, inv_i});
    unique case (state_q)
      H_MX: begin
        mul_a = px_q;
      end
      H_MY: begin
        mul_a = py_q;
      end
      H_MZ: begin
        mul_a = pz_q;
      end
      H_HX: begin
        mul_a = cx_q;
        mul_b = $signed(HASH_P1[MUL_B_W-1:0]);
      end
      H_HY: begin
        mul_a = cy_q;
        mul_b = $signed(HASH_P2[MUL_B_W-1:0]);
      end
      H_HZ: begin
        mul_a = cz_q;
        mul_b = $signed(HASH_P3[MUL_B_W-1:0]);
      end
      default: begin
        mul_a = px_q;
      end
    endcase
    // Only the low key bits of the prime products are kept
    prod_d = mul_a * mul_b;
  end

  // Answer: hold the cell, fold the last product into the key
  always_comb begin
    rsp_o.done   = (state_q == H_FIN);
    rsp_o.key    = acc_q ^ prod_q[KEY_W-1:0];
    rsp_o.cell_x = cx_q;
    rsp_o.cell_y = cy_q;
    rsp_o.cell_z = cz_q;
  end

  // Step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: capture positions, floor products into cells, fold hash terms
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == H_IDLE && req_i.start) begin
      px_q <= req_i.pos_x;
      py_q <= req_i.pos_y;
      pz_q <= req_i.pos_z;
    end
    if (state_q == H_MY) cx_q <= prod_q[FRAC_SH+POS_W-1:FRAC_SH];
    if (state_q == H_MZ) cy_q <= prod_q[FRAC_SH+POS_W-1:FRAC_SH];
    if (state_q == H_HX) cz_q <= prod_q[FRAC_SH+POS_W-1:FRAC_SH];
    if (state_q == H_HY) acc_q <= prod_q[KEY_W-1:0];
    if (state_q == H_HZ) acc_q <= acc_q ^ prod_q[KEY_W-1:0];
  end

endmodule

FILE: rtl/spatial_hash_grid_counting_sort.sv
// Spatial hash grid with counting sort: sequencer, particle/key/sorted stores.
// Every op gives one result beat. Build for N particles runs a zero sweep,
// a count pass, a prefix pass and a scatter pass, all on one port per store.
// One item at a time; busy high until the result.
// Reset clears count and built flag and loads the scale register with INV_RESET;
// stores need no clearing pass.
module spatial_hash_grid_counting_sort
  import shg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd_i,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [INV_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [INV_W-1:0] inv_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             built_q, built_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CS_AW-1:0] k_q, k_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] rstart_q, rstart_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;

  logic             accept;
  logic             is_full;
  logic             slot_over;
  logic [KEY_W-1:0] qkey;
  logic [CNT_W-1:0] slot_sum;

  hu_req_t hu_req;
  hu_rsp_t hu_rsp;

  // Store ports
  logic             pk_we;
  logic [IDX_W-1:0] pk_waddr, pk_raddr;
  logic [KEY_W-1:0] pk_wdata, pk_rdata;
  logic             cs_we;
  logic [CS_AW-1:0] cs_waddr, cs_raddr;
  logic [CNT_W-1:0] cs_wdata, cs_rdata;
  logic             fl_we;
  logic [KEY_W-1:0] fl_waddr, fl_raddr;
  logic [CNT_W-1:0] fl_wdata, fl_rdata;
  logic             so_we;
  logic [IDX_W-1:0] so_waddr, so_raddr;
  logic [IDX_W-1:0] so_wdata, so_rdata;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;
  assign is_full     = (count_q >= CNT_W'(MAX_PARTICLES));
  assign slot_over   = (CMP_W'(cmd_i.slot_index) >= CMP_W'(count_q));
  assign qkey        = KEY_W'(cmd_i.query_key);
  assign slot_sum    = cs_rdata + fl_rdata;
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(cmd_i.operation))
            OP_INSERT:     if (!is_full) state_d = S_HASH;
            OP_BUILD:      state_d = S_ZERO;
            OP_READ_SLOT:  if (built_q && !slot_over) state_d = S_SLOT_OUT;
            OP_READ_RANGE: if (built_q) state_d = S_RNG_A;
            default:       state_d = S_IDLE;
          endcase
        end
      end
      S_HASH:     if (hu_rsp.done) state_d = S_IDLE;
      S_ZERO:     if (k_q == CS_AW'(TABLE_SIZE)) state_d = S_CNT_RD;
      S_CNT_RD:   state_d = (i_q == count_q) ? S_PRE_RD : S_CNT_KEY;
      S_CNT_KEY:  state_d = S_CNT_INC;
      S_CNT_INC:  state_d = S_CNT_RD;
      S_PRE_RD:   state_d = S_PRE_WR;
      S_PRE_WR:   state_d = (k_q == CS_AW'(TABLE_SIZE)) ? S_SCT_RD : S_PRE_RD;
      S_SCT_RD:   state_d = (i_q == count_q) ? S_IDLE : S_SCT_KEY;
      S_SCT_KEY:  state_d = S_SCT_WR;
      S_SCT_WR:   state_d = S_SCT_RD;
      S_SLOT_OUT: state_d = S_IDLE;
      S_RNG_A:    state_d = S_RNG_B;
      S_RNG_B:    state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath, store controls and result
  always_comb begin
    count_d  = count_q;
    built_d  = built_q;
    i_d      = i_q;
    k_d      = k_q;
    key_d    = key_q;
    sum_d    = sum_q;
    rstart_d = rstart_q;
    done_d   = 1'b0;
    rsp_d    = '0;

    hu_req.start = 1'b0;
    hu_req.pos_x = cmd_i.pos_x;
    hu_req.pos_y = cmd_i.pos_y;
    hu_req.pos_z = cmd_i.pos_z;

    pk_we    = 1'b0;
    pk_waddr = IDX_W'(count_q);
    pk_wdata = hu_rsp.key;
    pk_raddr = IDX_W'(i_q);
    cs_we    = 1'b0;
    cs_waddr = k_q;
    cs_wdata = '0;
    cs_raddr = k_q;
    fl_we    = 1'b0;
    fl_waddr = KEY_W'(k_q);
    fl_wdata = '0;
    fl_raddr = key_q;
    so_we    = 1'b0;
    so_waddr = IDX_W'(slot_sum);
    so_wdata = IDX_W'(i_q);
    so_raddr = IDX_W'(cmd_i.slot_index);

    unique case (state_q)
      S_IDLE: begin
        cs_raddr = CS_AW'(qkey);
        if (accept) begin
          unique case (op_e'(cmd_i.operation))
            OP_CLEAR: begin
              count_d = '0;
              built_d = 1'b0;
              done_d  = 1'b1;
            end
            OP_INSERT: begin
              if (is_full) begin
                done_d       = 1'b1;
                rsp_d.status = ST_FULL;
              end else begin
                hu_req.start = 1'b1;
              end
            end
            OP_BUILD: begin
              k_d = '0;
            end
            OP_READ_SLOT: begin
              if (!built_q) begin
                done_d       = 1'b1;
                rsp_d.status = ST_NOT_BUILT;
              end else if (slot_over) begin
                done_d       = 1'b1;
                rsp_d.status = ST_RANGE;
              end
            end
            OP_READ_RANGE: begin
              if (!built_q) begin
                done_d       = 1'b1;
                rsp_d.status = ST_NOT_BUILT;
              end else begin
                key_d = qkey;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      // Store the key, count the particle, return key and cell
      S_HASH: begin
        if (hu_rsp.done) begin
          pk_we          = 1'b1;
          count_d        = count_q + CNT_W'(1);
          built_d        = 1'b0;
          done_d         = 1'b1;
          rsp_d.hash_key = HKEY_W'(hu_rsp.key);
          rsp_d.cell_x   = hu_rsp.cell_x;
          rsp_d.cell_y   = hu_rsp.cell_y;
          rsp_d.cell_z   = hu_rsp.cell_z;
        end
      end
      // Zero the start table and fill counters
      S_ZERO: begin
        cs_we = 1'b1;
        fl_we = (k_q < CS_AW'(TABLE_SIZE));
        k_d   = k_q + CS_AW'(1);
        if (k_q == CS_AW'(TABLE_SIZE)) begin
          i_d = '0;
        end
      end
      // Count pass: bump the entry after each key
      S_CNT_RD: begin
        if (i_q == count_q) begin
          k_d   = CS_AW'(1);
          sum_d = '0;
        end
      end
      S_CNT_KEY: begin
        key_d    = pk_rdata;
        cs_raddr = CS_AW'(pk_rdata) + CS_AW'(1);
      end
      S_CNT_INC: begin
        cs_we    = 1'b1;
        cs_waddr = CS_AW'(key_q) + CS_AW'(1);
        cs_wdata = cs_rdata + CNT_W'(1);
        i_d      = i_q + CNT_W'(1);
      end
      // Prefix pass: running sum over the table
      S_PRE_RD: begin
        cs_raddr = k_q;
      end
      S_PRE_WR: begin
        cs_we    = 1'b1;
        cs_waddr = k_q;
        cs_wdata = sum_q + cs_rdata;
        sum_d    = sum_q + cs_rdata;
        k_d      = k_q + CS_AW'(1);
        if (k_q == CS_AW'(TABLE_SIZE)) begin
          i_d = '0;
        end
      end
      // Scatter pass: place each particle at start plus fill
      S_SCT_RD: begin
        if (i_q == count_q) begin
          built_d = 1'b1;
          done_d  = 1'b1;
        end
      end
      S_SCT_KEY: begin
        key_d    = pk_rdata;
        cs_raddr = CS_AW'(pk_rdata);
        fl_raddr = pk_rdata;
      end
      S_SCT_WR: begin
        so_we    = 1'b1;
        fl_we    = 1'b1;
        fl_waddr = key_q;
        fl_wdata = fl_rdata + CNT_W'(1);
        i_d      = i_q + CNT_W'(1);
      end
      S_SLOT_OUT: begin
        done_d               = 1'b1;
        rsp_d.particle_index = PIDX_W'(so_rdata);
      end
      // Range read: start then end of the key
      S_RNG_A: begin
        rstart_d = cs_rdata;
        cs_raddr = CS_AW'(key_q) + CS_AW'(1);
      end
      S_RNG_B: begin
        done_d            = 1'b1;
        rsp_d.range_start = RNG_W'(rstart_q);
        rsp_d.range_end   = RNG_W'(cs_rdata);
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      inv_q   <= INV_RESET;
      count_q <= '0;
      built_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      built_q <= built_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        inv_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    k_q      <= k_d;
    key_q    <= key_d;
    sum_q    <= sum_d;
    rstart_q <= rstart_d;
    rsp_q    <= rsp_d;
  end

  shg_hash_unit u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .inv_i  (inv_q),
    .req_i  (hu_req),
    .rsp_o  (hu_rsp)
  );

  // Particle keys in insertion order
  shg_ram #(.WIDTH(KEY_W), .DEPTH(MAX_PARTICLES)) u_keys (
    .clk_i   (clk_i),
    .we_i    (pk_we),
    .waddr_i (pk_waddr),
    .wdata_i (pk_wdata),
    .raddr_i (pk_raddr),
    .rdata_o (pk_rdata)
  );

  // Per-key counts, then start slots after the prefix pass
  shg_ram #(.WIDTH(CNT_W), .DEPTH(CS_DEPTH)) u_starts (
    .clk_i   (clk_i),
    .we_i    (cs_we),
    .waddr_i (cs_waddr),
    .wdata_i (cs_wdata),
    .raddr_i (cs_raddr),
    .rdata_o (cs_rdata)
  );

  // Per-key fill counters for the scatter pass
  shg_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_SIZE)) u_fill (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .raddr_i (fl_raddr),
    .rdata_o (fl_rdata)
  );

  // Particle numbers in sorted order
  shg_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PARTICLES)) u_sorted (
    .clk_i   (clk_i),
    .we_i    (so_we),
    .waddr_i (so_waddr),
    .wdata_i (so_wdata),
    .raddr_i (so_raddr),
    .rdata_o (so_rdata)
  );

  // Count never runs past the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PARTICLES))
    else $error("particle count beyond store depth");

  // An insert into a full store answers full and stores nothing
  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.operation == OP_INSERT && is_full) |=>
      (done_o && rsp_o.status == ST_FULL && count_q == $past(count_q)))
    else $error("insert into full store not rejected");

  // Built flag only rises with a finished build beat
  a_built_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(built_q) |-> (done_q && rsp_q.status == ST_OK))
    else $error("built flag set without build result");

  // Hash answers only while the sequencer waits for one
  a_hash_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hu_rsp.done |-> (state_q == S_HASH))
    else $error("hash unit answered outside an insert");

endmodule

FILE: test/spatial_hash_grid_counting_sort_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for spatial_hash_grid_counting_sort: directed and random
// clear, insert, build and read traffic, checked against a behavioral grid model.
// Depends on shg_pkg and the spatial_hash_grid_counting_sort top level.
module spatial_hash_grid_counting_sort_tb;
  import shg_pkg::*;

  localparam int unsigned CLK_HALF_NS  = 2;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned STALL_LIMIT  = 50000;
  localparam int unsigned TAIL_CYCLES  = 32;
  localparam int unsigned RANDOM_ITEMS = 60;
  localparam int unsigned SCALE_PHASES = 6;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned IDLE_PCT     = 26;

  // Opcodes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [INV_W-1:0] SCALE_MIN = INV_W'(1);
  localparam logic [INV_W-1:0] SCALE_MAX = '1;

  typedef struct {
    cmd_t cmd;
    rsp_t rsp;
  } cmd_beat_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  cmd_t             cmd_i       = '0;
  logic             done_o;
  rsp_t             rsp_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [INV_W-1:0] cfg_data_i  = '0;

  // Grid model state
  logic [INV_W-1:0] grid_scale;
  logic [KEY_W-1:0] key_store  [MAX_PARTICLES];
  int unsigned      bin_start  [CS_DEPTH];
  int unsigned      bin_fill   [TABLE_SIZE];
  logic [IDX_W-1:0] sorted_ids [MAX_PARTICLES];
  int unsigned      stored_count;
  bit               grid_built;

  cmd_beat_t   pending_cmd_q [$];
  rsp_t        expected_rsp_q [$];
  event        beat_taken;
  bit          gaps_on = 1'b1;

  int unsigned items_sent      = 0;
  int unsigned builds_sent     = 0;
  int unsigned scale_writes    = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned stalled_cycles  = 0;

  spatial_hash_grid_counting_sort i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #CLK_HALF_NS clk_i = 1'b1;
    #CLK_HALF_NS clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Grid model
  // ---------------------------------------------------------------------------

  // floor(pos * scale / 2^16); the arithmetic shift floors negative products
  function automatic logic signed [POS_W-1:0] scaled_cell(input logic signed [POS_W-1:0] pos);
    logic signed [MUL_P_W-1:0] prod;
    prod = pos * $signed({1'b0, grid_scale});
    return POS_W'(prod >>> FRAC_SH);
  endfunction

  function automatic logic [KEY_W-1:0] cell_hash(input logic signed [POS_W-1:0] cx,
                                                 input logic signed [POS_W-1:0] cy,
                                                 input logic signed [POS_W-1:0] cz);
    logic [31:0] hx, hy, hz;
    hx = 32'(cx) * HASH_P1;
    hy = 32'(cy) * HASH_P2;
    hz = 32'(cz) * HASH_P3;
    return KEY_W'(hx ^ hy ^ hz);
  endfunction

  function automatic void zero_bins();
    for (int k = 0; k < CS_DEPTH; k++) bin_start[k] = 0;
    for (int k = 0; k < TABLE_SIZE; k++) bin_fill[k] = 0;
  endfunction

  // Count per key, prefix sum, then scatter particle numbers in insertion order
  function automatic void rebuild_bins();
    int unsigned key;
    int unsigned slot;
    zero_bins();
    for (int i = 0; i < stored_count; i++) bin_start[int'(key_store[i]) + 1]++;
    for (int k = 0; k < TABLE_SIZE; k++) bin_start[k + 1] += bin_start[k];
    for (int i = 0; i < stored_count; i++) begin
      key  = key_store[i];
      slot = bin_start[key] + bin_fill[key];
      bin_fill[key]++;
      sorted_ids[slot] = IDX_W'(i);
    end
    grid_built = 1'b1;
  endfunction

  // Advance the model by one command beat and return the response it owes
  function automatic rsp_t grid_step(input cmd_t c);
    rsp_t r;
    logic signed [POS_W-1:0] cx, cy, cz;
    r = '0;
    case (c.operation)
      OP_CLEAR: begin
        stored_count = 0;
        grid_built   = 1'b0;
        zero_bins();
      end
      OP_INSERT: begin
        if (stored_count >= MAX_PARTICLES) begin
          r.status = ST_FULL;
        end else begin
          cx = scaled_cell(c.pos_x);
          cy = scaled_cell(c.pos_y);
          cz = scaled_cell(c.pos_z);
          r.hash_key = cell_hash(cx, cy, cz);
          r.cell_x   = cx;
          r.cell_y   = cy;
          r.cell_z   = cz;
          key_store[stored_count] = r.hash_key;
          stored_count++;
          grid_built = 1'b0;
        end
      end
      OP_BUILD: rebuild_bins();
      OP_READ_SLOT: begin
        if (!grid_built) r.status = ST_NOT_BUILT;
        else if (c.slot_index >= stored_count) r.status = ST_RANGE;
        else r.particle_index = sorted_ids[c.slot_index];
      end
      OP_READ_RANGE: begin
        if (!grid_built) begin
          r.status = ST_NOT_BUILT;
        end else begin
          r.range_start = RNG_W'(bin_start[c.query_key]);
          r.range_end   = RNG_W'(bin_start[int'(c.query_key) + 1]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  function automatic cmd_t random_cmd(input logic [OP_W-1:0] op);
    cmd_t c;
    c.operation  = op;
    c.pos_x      = POS_W'($urandom());
    c.pos_y      = POS_W'($urandom());
    c.pos_z      = POS_W'($urandom());
    c.slot_index = SLOT_W'($urandom());
    c.query_key  = QKEY_W'($urandom());
    return c;
  endfunction

  function automatic logic signed [POS_W-1:0] near_origin();
    return POS_W'(int'($urandom_range(0, 2047)) - 1024);
  endfunction

  // Queue one beat with its predicted response; keep at most one beat in reserve
  task automatic send_cmd(input cmd_t c);
    cmd_beat_t b;
    while (pending_cmd_q.size() >= 2) @(beat_taken);
    b.cmd = c;
    b.rsp = grid_step(c);
    pending_cmd_q.push_back(b);
    if (c.operation <= OP_READ_RANGE) items_sent++;
    if (c.operation == OP_BUILD) builds_sent++;
  endtask

  task automatic wait_drained();
    while (pending_cmd_q.size() != 0 || expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Write the cell scale only with the block idle
  task automatic write_scale(input logic [INV_W-1:0] scale);
    wait_drained();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= scale;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    grid_scale = scale;
    scale_writes++;
  endtask

  // Take the beat on handshake, then present the next one or idle
  always @(posedge clk_i) begin
    if (start && !busy) begin
      expected_rsp_q.push_back(pending_cmd_q[0].rsp);
      pending_cmd_q.pop_front();
      -> beat_taken;
    end
    if (pending_cmd_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < IDLE_PCT)) begin
      start <= 1'b1;
      cmd_i <= pending_cmd_q[0].cmd;
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Response checking
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) flag_error($sformatf("%s expected %0d, actual %0d", name, want, got));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        flag_error("response beat with no command outstanding");
      end else begin
        check_field("status", expected_rsp_q[0].status, rsp_o.status);
        check_field("hash_key", expected_rsp_q[0].hash_key, rsp_o.hash_key);
        check_field("cell_x", $signed(expected_rsp_q[0].cell_x), $signed(rsp_o.cell_x));
        check_field("cell_y", $signed(expected_rsp_q[0].cell_y), $signed(rsp_o.cell_y));
        check_field("cell_z", $signed(expected_rsp_q[0].cell_z), $signed(rsp_o.cell_z));
        check_field("particle_index", expected_rsp_q[0].particle_index,
                    rsp_o.particle_index);
        check_field("range_start", expected_rsp_q[0].range_start, rsp_o.range_start);
        check_field("range_end", expected_rsp_q[0].range_end, rsp_o.range_end);
        expected_rsp_q.pop_front();
        results_checked++;
      end
    end
  end

  // Stop a hung run: count cycles with no beat moving on any channel
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) stalled_cycles = 0;
    else stalled_cycles++;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake", STALL_LIMIT);
      $display("spatial_hash_grid_counting_sort: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reads_before_build();
    cmd_t c;
    c = random_cmd(OP_READ_SLOT);
    c.slot_index = '0;
    send_cmd(c);
    c = random_cmd(OP_READ_RANGE);
    c.query_key = '1;
    send_cmd(c);
  endtask

  task automatic test_unused_ops();
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) send_cmd(random_cmd(OP_W'(op)));
  endtask

  task automatic test_empty_build();
    cmd_t c;
    send_cmd(random_cmd(OP_BUILD));
    c = random_cmd(OP_READ_SLOT);
    c.slot_index = '0;
    send_cmd(c);
    send_cmd(random_cmd(OP_READ_RANGE));
  endtask

  // Position extremes, negative floors, and both scale extremes
  task automatic test_insert_extremes();
    cmd_t c;
    c = random_cmd(OP_INSERT);
    {c.pos_x, c.pos_y, c.pos_z} = {POS_MAX, POS_MIN, POS_W'(0)};
    send_cmd(c);
    {c.pos_x, c.pos_y, c.pos_z} = {POS_W'(-1), POS_W'(1), POS_W'(-256)};
    send_cmd(c);
    {c.pos_x, c.pos_y, c.pos_z} = {POS_MIN, POS_MAX, POS_MAX};
    send_cmd(c);
    write_scale(SCALE_MAX);
    {c.pos_x, c.pos_y, c.pos_z} = {POS_MAX, POS_MIN, POS_W'(-1)};
    send_cmd(c);
    write_scale(SCALE_MIN);
    send_cmd(c);
  endtask

  task automatic test_rebuild_and_reads();
    cmd_t c;
    send_cmd(random_cmd(OP_BUILD));
    send_cmd(random_cmd(OP_BUILD));
    c = random_cmd(OP_READ_SLOT);
    c.slot_index = '0;
    send_cmd(c);
    c.slot_index = SLOT_W'(stored_count - 1);
    send_cmd(c);
    c.slot_index = '1;
    send_cmd(c);
    c = random_cmd(OP_READ_RANGE);
    c.query_key = key_store[0];
    send_cmd(c);
    c.query_key = '1;
    send_cmd(c);
  endtask

  task automatic test_insert_after_build();
    cmd_t c;
    send_cmd(random_cmd(OP_INSERT));
    c = random_cmd(OP_READ_SLOT);
    c.slot_index = '0;
    send_cmd(c);
  endtask

  task automatic test_clear();
    send_cmd(random_cmd(OP_CLEAR));
    send_cmd(random_cmd(OP_READ_RANGE));
  endtask

  // One well-formed pass: usually a clear, inserts, build, reads, with some noise mixed in
  task automatic random_sequence();
    int unsigned n_ins;
    int unsigned n_reads;
    bit          clustered;
    cmd_t        c;
    clustered = ($urandom_range(0, 1) == 0);
    if (stored_count > 800 || $urandom_range(0, 3) != 0) send_cmd(random_cmd(OP_CLEAR));
    n_ins = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
    repeat (n_ins) begin
      c = random_cmd(OP_INSERT);
      if (clustered) {c.pos_x, c.pos_y, c.pos_z} = {near_origin(), near_origin(), near_origin()};
      send_cmd(c);
    end
    // hold off now and then until the block has caught up
    if ($urandom_range(0, 7) == 0) wait_drained();
    send_cmd(random_cmd(OP_BUILD));
    if ($urandom_range(0, 4) == 0) send_cmd(random_cmd(OP_BUILD));
    n_reads = $urandom_range(3, 12);
    repeat (n_reads) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 2))
            0: c = random_cmd(OP_INSERT);
            1: c = random_cmd(OP_CLEAR);
            default: c = random_cmd(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
          endcase
        end
        1, 2, 3, 4, 5: begin
          c = random_cmd(OP_READ_SLOT);
          if (stored_count > 0 && $urandom_range(0, 4) != 0)
            c.slot_index = SLOT_W'($urandom_range(0, stored_count - 1));
        end
        default: begin
          c = random_cmd(OP_READ_RANGE);
          if (stored_count > 0 && $urandom_range(0, 3) != 0)
            c.query_key = key_store[$urandom_range(0, stored_count - 1)];
        end
      endcase
      send_cmd(c);
    end
  endtask

  // Sweep several cell scales; one phase runs without sender gaps
  task automatic test_random_traffic();
    logic [INV_W-1:0] scales [SCALE_PHASES];
    int unsigned      budget;
    scales = '{INV_RESET, SCALE_MIN, SCALE_MAX, INV_W'(16),
               INV_W'($urandom_range(2, 65534)), INV_W'($urandom_range(2, 1023))};
    for (int p = 0; p < SCALE_PHASES; p++) begin
      write_scale(scales[p]);
      gaps_on = (p != 3);
      budget  = items_sent + RANDOM_ITEMS / SCALE_PHASES;
      while (items_sent < budget) random_sequence();
    end
    gaps_on = 1'b1;
  endtask

  // Fill the store, overflow it, and read the last sorted slot and the last key's range
  task automatic test_table_full();
    cmd_t c;
    send_cmd(random_cmd(OP_CLEAR));
    // first half of the fill back to back, second half with gaps
    gaps_on = 1'b0;
    repeat (MAX_PARTICLES / 2) send_cmd(random_cmd(OP_INSERT));
    gaps_on = 1'b1;
    repeat (MAX_PARTICLES - MAX_PARTICLES / 2) send_cmd(random_cmd(OP_INSERT));
    send_cmd(random_cmd(OP_INSERT));
    send_cmd(random_cmd(OP_BUILD));
    send_cmd(random_cmd(OP_INSERT));
    c = random_cmd(OP_READ_SLOT);
    c.slot_index = '1;
    send_cmd(c);
    c = random_cmd(OP_READ_RANGE);
    c.query_key = key_store[MAX_PARTICLES - 1];
    send_cmd(c);
  endtask

  initial begin
    grid_scale   = INV_RESET;
    stored_count = 0;
    grid_built   = 1'b0;
    zero_bins();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reads_before_build();
    test_unused_ops();
    test_empty_build();
    test_insert_extremes();
    test_rebuild_and_reads();
    test_insert_after_build();
    test_clear();
    test_random_traffic();
    test_table_full();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("run covered %0d commands with %0d builds over %0d scale settings",
             items_sent, builds_sent, scale_writes);
    $display("%0d responses compared, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("spatial_hash_grid_counting_sort: match");
    end else begin
      $display("spatial_hash_grid_counting_sort: mismatch");
    end
    $finish;
  end

endmodule
